// ===== design/fbdrt_pkg.sv =====
// ----------------------------------------------------------------------------
// fbdrt_pkg: shared types and constants for the dirty-rectangle frame store
// Frame geometry, request codes, register indexes and the queue word.
// ----------------------------------------------------------------------------
package fbdrt_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int Y_W         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = X_W + Y_W;
    localparam int DIM_W       = 10;
    localparam int COLOR_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int FRAME_RESET = 512;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_req               kind;
        logic               in_range;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] color;
        logic [DIM_W-1:0]   act_w;
        logic [DIM_W-1:0]   act_h;
    } t_fifo_word;

endpackage

// ===== design/fbdrt_front.sv =====
// ----------------------------------------------------------------------------
// fbdrt_front: request intake and classification
// Holds the frame registers, range-checks each request and queues it.
// ----------------------------------------------------------------------------
module fbdrt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [1:0]                          i_req_type,
    input  logic [fbdrt_pkg::X_W-1:0]           i_pos_x,
    input  logic [fbdrt_pkg::Y_W-1:0]           i_pos_y,
    input  logic [fbdrt_pkg::COLOR_W-1:0]       i_color,
    input  logic                                i_cfg_we,
    input  logic [fbdrt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbdrt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_fifo_full,
    input  logic                                i_sweeping,
    output logic                                o_busy,
    output logic                                o_push,
    output fbdrt_pkg::t_fifo_word               o_word,
    output logic                                o_resize
);

    logic [fbdrt_pkg::DIM_W-1:0] r_frame_width;
    logic [fbdrt_pkg::DIM_W-1:0] r_frame_height;
    logic [fbdrt_pkg::DIM_W-1:0] n_frame_width;
    logic [fbdrt_pkg::DIM_W-1:0] n_frame_height;
    logic [fbdrt_pkg::DIM_W-1:0] act_w;
    logic [fbdrt_pkg::DIM_W-1:0] act_h;

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        o_resize       = 1'b0;
        if (i_cfg_we) begin
            case (fbdrt_pkg::t_cfg_idx'(i_cfg_index))
                fbdrt_pkg::CFG_FRAME_WIDTH: begin
                    if (i_cfg_data != r_frame_width) begin
                        n_frame_width = i_cfg_data;
                        o_resize      = 1'b1;
                    end
                end
                fbdrt_pkg::CFG_FRAME_HEIGHT: begin
                    if (i_cfg_data != r_frame_height) begin
                        n_frame_height = i_cfg_data;
                        o_resize       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fbdrt_pkg::DIM_W'(fbdrt_pkg::FRAME_RESET);
            r_frame_height <= fbdrt_pkg::DIM_W'(fbdrt_pkg::FRAME_RESET);
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
        end
    end

    assign act_w = (r_frame_width > fbdrt_pkg::DIM_W'(fbdrt_pkg::MAX_WIDTH))
                 ? fbdrt_pkg::DIM_W'(fbdrt_pkg::MAX_WIDTH) : r_frame_width;
    assign act_h = (r_frame_height > fbdrt_pkg::DIM_W'(fbdrt_pkg::MAX_HEIGHT))
                 ? fbdrt_pkg::DIM_W'(fbdrt_pkg::MAX_HEIGHT) : r_frame_height;

    always_comb begin
        o_word.kind     = fbdrt_pkg::t_req'(i_req_type);
        o_word.in_range = (fbdrt_pkg::DIM_W'(i_pos_x) < act_w)
                       && (fbdrt_pkg::DIM_W'(i_pos_y) < act_h);
        o_word.x        = i_pos_x;
        o_word.y        = i_pos_y;
        o_word.color    = i_color;
        o_word.act_w    = act_w;
        o_word.act_h    = act_h;
    end

    assign o_busy = i_fifo_full | i_sweeping;
    assign o_push = i_start & ~o_busy;

endmodule

// ===== design/fbdrt_fifo.sv =====
// ----------------------------------------------------------------------------
// fbdrt_fifo: request queue between intake and execution
// Small first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
module fbdrt_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  fbdrt_pkg::t_fifo_word  i_word,
    input  logic                   i_pop,
    output fbdrt_pkg::t_fifo_word  o_word,
    output logic                   o_full,
    output logic                   o_empty
);

    fbdrt_pkg::t_fifo_word r_slot [fbdrt_pkg::FIFO_DEPTH];
    logic [fbdrt_pkg::FIFO_PTR_W-1:0] r_wptr;
    logic [fbdrt_pkg::FIFO_PTR_W-1:0] r_rptr;
    logic [fbdrt_pkg::FIFO_CNT_W-1:0] r_count;
    logic [fbdrt_pkg::FIFO_PTR_W-1:0] n_wptr;
    logic [fbdrt_pkg::FIFO_PTR_W-1:0] n_rptr;
    logic [fbdrt_pkg::FIFO_CNT_W-1:0] n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == fbdrt_pkg::FIFO_CNT_W'(fbdrt_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_word  = r_slot[r_rptr];

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_word;
        end
    end

endmodule

// ===== design/fbdrt_back.sv =====
// ----------------------------------------------------------------------------
// fbdrt_back: request execution
// Owns the pixel store, the dirty rectangle, the clearing sweep and results.
// ----------------------------------------------------------------------------
module fbdrt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fbdrt_pkg::t_fifo_word             i_word,
    input  logic                              i_empty,
    input  logic                              i_resize,
    output logic                              o_pop,
    output logic                              o_sweeping,
    output logic                              o_done,
    output logic [fbdrt_pkg::COLOR_W-1:0]     o_read_value,
    output logic                              o_was_dirty,
    output logic [fbdrt_pkg::X_W-1:0]         o_dirty_left,
    output logic [fbdrt_pkg::Y_W-1:0]         o_dirty_top,
    output logic [fbdrt_pkg::DIM_W-1:0]       o_dirty_right,
    output logic [fbdrt_pkg::DIM_W-1:0]       o_dirty_bottom,
    output logic                              o_status
);

    logic [fbdrt_pkg::COLOR_W-1:0] r_mem [2**fbdrt_pkg::ADDR_W];

    logic                          r_sweep;
    logic [fbdrt_pkg::ADDR_W-1:0]  r_sweep_addr;
    logic                          r_region_valid;
    logic [fbdrt_pkg::X_W-1:0]     r_region_left;
    logic [fbdrt_pkg::Y_W-1:0]     r_region_top;
    logic [fbdrt_pkg::DIM_W-1:0]   r_region_right;
    logic [fbdrt_pkg::DIM_W-1:0]   r_region_bottom;
    logic                          r_done;
    logic                          r_was_dirty;
    logic [fbdrt_pkg::X_W-1:0]     r_left;
    logic [fbdrt_pkg::Y_W-1:0]     r_top;
    logic [fbdrt_pkg::DIM_W-1:0]   r_right;
    logic [fbdrt_pkg::DIM_W-1:0]   r_bottom;
    logic                          r_status;
    logic                          r_rd_ok;
    logic [fbdrt_pkg::COLOR_W-1:0] r_mem_q;

    logic                          n_sweep;
    logic [fbdrt_pkg::ADDR_W-1:0]  n_sweep_addr;
    logic                          n_region_valid;
    logic [fbdrt_pkg::X_W-1:0]     n_region_left;
    logic [fbdrt_pkg::Y_W-1:0]     n_region_top;
    logic [fbdrt_pkg::DIM_W-1:0]   n_region_right;
    logic [fbdrt_pkg::DIM_W-1:0]   n_region_bottom;

    logic [fbdrt_pkg::ADDR_W-1:0]  addr;
    logic [fbdrt_pkg::DIM_W-1:0]   x_end;
    logic [fbdrt_pkg::DIM_W-1:0]   y_end;
    logic                          pix_op;
    logic                          do_write;
    logic                          do_read;

    assign o_pop    = ~i_empty & ~r_sweep;
    assign addr     = {i_word.y, i_word.x};
    assign x_end    = fbdrt_pkg::DIM_W'(i_word.x) + 1'b1;
    assign y_end    = fbdrt_pkg::DIM_W'(i_word.y) + 1'b1;
    assign pix_op   = (i_word.kind == fbdrt_pkg::REQ_WRITE)
                   || (i_word.kind == fbdrt_pkg::REQ_READ);
    assign do_write = o_pop && (i_word.kind == fbdrt_pkg::REQ_WRITE) && i_word.in_range;
    assign do_read  = o_pop && (i_word.kind == fbdrt_pkg::REQ_READ) && i_word.in_range;

    always_comb begin
        n_sweep         = r_sweep;
        n_sweep_addr    = r_sweep_addr;
        n_region_valid  = r_region_valid;
        n_region_left   = r_region_left;
        n_region_top    = r_region_top;
        n_region_right  = r_region_right;
        n_region_bottom = r_region_bottom;
        if (r_sweep) begin
            n_sweep_addr = r_sweep_addr + 1'b1;
            if (&r_sweep_addr) begin
                n_sweep = 1'b0;
            end
        end
        if (i_resize) begin
            n_sweep         = 1'b1;
            n_sweep_addr    = '0;
            n_region_valid  = 1'b0;
            n_region_left   = '0;
            n_region_top    = '0;
            n_region_right  = '0;
            n_region_bottom = '0;
        end else if (o_pop) begin
            case (i_word.kind)
                fbdrt_pkg::REQ_WRITE: begin
                    if (i_word.in_range) begin
                        n_region_valid = 1'b1;
                        if (!r_region_valid) begin
                            n_region_left   = i_word.x;
                            n_region_top    = i_word.y;
                            n_region_right  = x_end;
                            n_region_bottom = y_end;
                        end else begin
                            if (i_word.x < r_region_left) n_region_left = i_word.x;
                            if (i_word.y < r_region_top)  n_region_top  = i_word.y;
                            if (x_end > r_region_right)   n_region_right  = x_end;
                            if (y_end > r_region_bottom)  n_region_bottom = y_end;
                        end
                    end
                end
                fbdrt_pkg::REQ_FLUSH: begin
                    n_region_valid  = 1'b0;
                    n_region_left   = '0;
                    n_region_top    = '0;
                    n_region_right  = '0;
                    n_region_bottom = '0;
                end
                fbdrt_pkg::REQ_CLEAR: begin
                    n_sweep         = 1'b1;
                    n_sweep_addr    = '0;
                    n_region_valid  = 1'b1;
                    n_region_left   = '0;
                    n_region_top    = '0;
                    n_region_right  = i_word.act_w;
                    n_region_bottom = i_word.act_h;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep         <= 1'b1;
            r_sweep_addr    <= '0;
            r_region_valid  <= 1'b0;
            r_region_left   <= '0;
            r_region_top    <= '0;
            r_region_right  <= '0;
            r_region_bottom <= '0;
            r_done          <= 1'b0;
        end else begin
            r_sweep         <= n_sweep;
            r_sweep_addr    <= n_sweep_addr;
            r_region_valid  <= n_region_valid;
            r_region_left   <= n_region_left;
            r_region_top    <= n_region_top;
            r_region_right  <= n_region_right;
            r_region_bottom <= n_region_bottom;
            r_done          <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_was_dirty <= r_region_valid;
            r_left      <= r_region_left;
            r_top       <= r_region_top;
            r_right     <= r_region_right;
            r_bottom    <= r_region_bottom;
            r_status    <= pix_op && !i_word.in_range;
            r_rd_ok     <= do_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep) begin
            r_mem[r_sweep_addr] <= '0;
        end else if (do_write) begin
            r_mem[addr] <= i_word.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_mem_q <= r_mem[addr];
        end
    end

    assign o_sweeping     = r_sweep;
    assign o_done         = r_done;
    assign o_read_value   = r_rd_ok ? r_mem_q : '0;
    assign o_was_dirty    = r_was_dirty;
    assign o_dirty_left   = r_left;
    assign o_dirty_top    = r_top;
    assign o_dirty_right  = r_right;
    assign o_dirty_bottom = r_bottom;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_clean_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_was_dirty) |->
        (r_left == '0 && r_top == '0 && r_right == '0 && r_bottom == '0))
        else $error("clean region reported with nonzero edges");

    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sweep |-> (r_sweep_addr == '0))
        else $error("sweep address moved outside a sweep");

    a_region_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_region_valid |->
        (r_region_right >= fbdrt_pkg::DIM_W'(r_region_left)
         && r_region_bottom >= fbdrt_pkg::DIM_W'(r_region_top)))
        else $error("dirty rectangle edges out of order");
`endif

endmodule

// ===== design/framebuffer_dirty_rect_tracker.sv =====
// ----------------------------------------------------------------------------
// framebuffer_dirty_rect_tracker: 8-bit frame store with dirty rectangle
// Pixel write, read, flush and clear requests with bounding-box tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request word on i_req_type/i_pos_x/i_pos_y/i_color and raise
//   i_start; the word is taken on a clock edge where o_busy is low.
//   Every request yields one result, shown for one cycle with o_done high.
//   With the queue empty, an accepted request is queued, popped, executed
//   and its result registered with o_done; while o_busy is low a new
//   request may be taken every cycle, one pixel-store access per cycle.
//   A four-entry queue sits between intake and execution.
//   A clear request zeroes the store with a sweep, one pixel a cycle;
//   later requests wait in the queue and o_busy rises once the sweep
//   runs or the queue fills.
//   Reset runs the same sweep, with o_busy high throughout.
//   Writing a frame register with a new value empties the rectangle and
//   starts the sweep as well; write registers only while idle.
//   The receiver cannot stall: results must be taken as they appear.
// ----------------------------------------------------------------------------
module framebuffer_dirty_rect_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_req_type,
    input  logic [fbdrt_pkg::X_W-1:0]         i_pos_x,
    input  logic [fbdrt_pkg::Y_W-1:0]         i_pos_y,
    input  logic [fbdrt_pkg::COLOR_W-1:0]     i_color,
    input  logic                              i_cfg_we,
    input  logic [fbdrt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbdrt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                              o_done,
    output logic [fbdrt_pkg::COLOR_W-1:0]     o_read_value,
    output logic                              o_was_dirty,
    output logic [fbdrt_pkg::X_W-1:0]         o_dirty_left,
    output logic [fbdrt_pkg::Y_W-1:0]         o_dirty_top,
    output logic [fbdrt_pkg::DIM_W-1:0]       o_dirty_right,
    output logic [fbdrt_pkg::DIM_W-1:0]       o_dirty_bottom,
    output logic                              o_status
);

    fbdrt_pkg::t_fifo_word push_word;
    fbdrt_pkg::t_fifo_word head_word;
    logic                  push;
    logic                  pop;
    logic                  fifo_full;
    logic                  fifo_empty;
    logic                  sweeping;
    logic                  resize;

    fbdrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_color     (i_color),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_full (fifo_full),
        .i_sweeping  (sweeping),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_word      (push_word),
        .o_resize    (resize)
    );

    fbdrt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    fbdrt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (head_word),
        .i_empty        (fifo_empty),
        .i_resize       (resize),
        .o_pop          (pop),
        .o_sweeping     (sweeping),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_was_dirty    (o_was_dirty),
        .o_dirty_left   (o_dirty_left),
        .o_dirty_top    (o_dirty_top),
        .o_dirty_right  (o_dirty_right),
        .o_dirty_bottom (o_dirty_bottom),
        .o_status       (o_status)
    );

endmodule
